// File: sv/csa_pkg.sv
// Shared types and constants for the calibrated sensor-to-angle block.
// No dependencies; imported by csa_ctrl, csa_dp and the top level.
package csa_pkg;

  localparam int SampleBitsDef = 12;
  localparam int CountW        = 10;
  localparam int AngleW        = 8;
  localparam int CfgDataW      = 10;
  localparam int CfgIdxW       = 2;
  localparam int DivSteps      = AngleW;
  localparam int StepW         = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CfgCalibSamples = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxAngle     = CfgIdxW'(1);

  localparam logic [CountW-1:0] CalibSamplesRst = CountW'(100);
  localparam logic [AngleW-1:0] MaxAngleRst     = AngleW'(179);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // capture a request and classify it
    logic mul;       // form the scaled numerator
    logic div_step;  // one restoring division step
    logic load_out;  // move the result into the output register
  } csa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic direct;    // result known at capture, no division needed
  } csa_sts_t;

endpackage

// File: sv/calibrated_sensor_to_angle_core.sv
// Top level of the calibrated sensor-to-angle block.
// Depends on csa_pkg, csa_ctrl and csa_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------
//  in      | in_valid, in_stall  | sample
//  out     | out_valid, out_stall| angle, calibrating, indicator
//  cfg     | cfg_we (no wait)    | cfg_index, cfg_data
//
// A calibration request passes through capture and result hand-off. A mapped
// request whose result is known at capture (empty range, at or beyond an
// extreme) does the same; otherwise it passes through capture, a multiply
// step, eight restoring divide steps (one quotient bit each) and hand-off.
// Reset is synchronous and restores the calibration state and register
// defaults. A result waiting on out_stall holds in the output register while
// the next request is accepted and worked on; that request then holds in its
// hand-off step until the output register frees.
module calibrated_sensor_to_angle_core #(
  parameter int SAMPLE_BITS = csa_pkg::SampleBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [csa_pkg::AngleW-1:0]    angle,
  output logic                          calibrating,
  output logic                          indicator,
  input  logic                          cfg_we,
  input  logic [csa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [csa_pkg::CfgDataW-1:0]  cfg_data
);
  import csa_pkg::*;

  csa_cmd_t cmd;
  csa_sts_t sts;

  // Sequence each request: capture, optional multiply and divide, hand-off.
  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Track extremes, blink, map samples and hold the output payload.
  csa_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .angle       (angle),
    .calibrating (calibrating),
    .indicator   (indicator)
  );

endmodule

// File: sv/csa_ctrl.sv
// Controller for the sensor-to-angle block: sequences capture, multiply,
// serial divide and result hand-off. Depends on csa_pkg.
module csa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  csa_pkg::csa_sts_t sts,
  output csa_pkg::csa_cmd_t cmd
);
  import csa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_DIV   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [StepW-1:0] step;
  logic             take, out_free;

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = sts.direct ? S_WRITE : S_MUL;
      S_MUL:   state_next = S_DIV;
      S_DIV:   if (step == StepW'(DivSteps - 1)) state_next = S_WRITE;
      S_WRITE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.take     = take;
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.load_out = (state == S_WRITE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) step <= step + StepW'(1);
      else                step <= '0;
      if (cmd.load_out)    out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/csa_dp.sv
// Datapath for the sensor-to-angle block: calibration state, configuration,
// multiplier, restoring divider and output register. Depends on csa_pkg.
module csa_dp #(
  parameter int SAMPLE_BITS = csa_pkg::SampleBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          cfg_we,
  input  logic [csa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [csa_pkg::CfgDataW-1:0]  cfg_data,
  input  csa_pkg::csa_cmd_t             cmd,
  output csa_pkg::csa_sts_t             sts,
  output logic [csa_pkg::AngleW-1:0]    angle,
  output logic                          calibrating,
  output logic                          indicator
);
  import csa_pkg::*;

  localparam int ProdW = SAMPLE_BITS + AngleW;

  logic [CountW-1:0]      calib_samples, calib_count;
  logic [AngleW-1:0]      max_angle;
  logic [SAMPLE_BITS-1:0] low_seen, high_seen;
  logic                   blink_level;

  logic [SAMPLE_BITS-1:0] diff, range_w, rem;
  logic [AngleW-1:0]      quo;
  logic                   res_cal, res_ind;

  logic                   in_calib, empty_range, at_low, at_high;
  logic [ProdW-1:0]       prod;
  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;

  assign in_calib    = (calib_count < calib_samples);
  assign empty_range = (high_seen <= low_seen);
  assign at_low      = (sample <= low_seen);
  assign at_high     = (sample >= high_seen);
  assign sts.direct  = in_calib || empty_range || at_low || at_high;

  assign prod  = ProdW'(diff) * ProdW'(max_angle);
  assign trial = {rem, quo[AngleW-1]};
  assign fits  = (trial >= {1'b0, range_w});

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_samples <= CalibSamplesRst;
      max_angle     <= MaxAngleRst;
      low_seen      <= '1;
      high_seen     <= '0;
      calib_count   <= '0;
      blink_level   <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgCalibSamples: calib_samples <= cfg_data[CountW-1:0];
          CfgMaxAngle:     max_angle     <= cfg_data[AngleW-1:0];
          default: ;
        endcase
      end
      if (cmd.take && in_calib) begin
        if (sample < low_seen)  low_seen  <= sample;
        if (sample > high_seen) high_seen <= sample;
        if (!calib_count[0])    blink_level <= !blink_level;
        calib_count <= calib_count + CountW'(1);
      end
    end
  end

  // Numerator is below range * 2^AngleW, so the quotient fits in AngleW bits.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      diff    <= sample - low_seen;
      range_w <= high_seen - low_seen;
      res_cal <= in_calib;
      res_ind <= in_calib && blink_level;
      if (in_calib || empty_range || at_low) quo <= '0;
      else                                   quo <= max_angle;
    end else if (cmd.mul) begin
      rem <= prod[ProdW-1:AngleW];
      quo <= prod[AngleW-1:0];
    end else if (cmd.div_step) begin
      rem <= fits ? SAMPLE_BITS'(trial - {1'b0, range_w}) : trial[SAMPLE_BITS-1:0];
      quo <= {quo[AngleW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      angle       <= quo;
      calibrating <= res_cal;
      indicator   <= res_ind;
    end
  end

endmodule
